@@ hdl/header_field_scan_and_capture_assert.svh @@
// ----------------------------------------------------------------------------
// header field scan and capture: assertion macros
// Shared concurrent assertion forms used by the block's modules.
// ----------------------------------------------------------------------------
`ifndef HEADER_FIELD_SCAN_AND_CAPTURE_ASSERT_SVH
`define HEADER_FIELD_SCAN_AND_CAPTURE_ASSERT_SVH

// condition holds at every edge out of reset
`define HFSC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("hfsc: invariant violated");

// consequence holds in the same cycle as the antecedent
`define HFSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hfsc: implication violated");

// consequence holds in the cycle after the antecedent
`define HFSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hfsc: next-cycle implication violated");

`endif

@@ hdl/hfsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hfsc_pkg
// Types, constants and helpers shared by the header field scan blocks.
// ----------------------------------------------------------------------------
package hfsc_pkg;

  localparam int MAX_PATTERN = 24;
  localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
  localparam int MAX_CAPTURE = 1024;
  localparam int LIMIT_W     = 11;
  localparam int COUNT_W     = 10;
  localparam int PLEN_W      = 5;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [7:0] NEWLINE     = 8'h0A;
  localparam logic [7:0] STOP_RESET  = 8'h3E;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd256;

  localparam logic [2:0] REG_PAT_LOW   = 3'd0;
  localparam logic [2:0] REG_PAT_MID   = 3'd1;
  localparam logic [2:0] REG_PAT_HIGH  = 3'd2;
  localparam logic [2:0] REG_PAT_LEN   = 3'd3;
  localparam logic [2:0] REG_ONELINE   = 3'd4;
  localparam logic [2:0] REG_STOP_BYTE = 3'd5;
  localparam logic [2:0] REG_INVERT    = 3'd6;
  localparam logic [2:0] REG_LIMIT     = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEARCH,
    PH_CAPTURE,
    PH_FINISHED
  } phase_e;

  typedef enum logic [1:0] {
    ST_BYTE,
    ST_DONE,
    ST_NOT_FOUND,
    ST_ERROR
  } status_e;

  typedef struct packed {
    logic [63:0]         pat_low;
    logic [63:0]         pat_mid;
    logic [63:0]         pat_high;
    logic [PLEN_W-1:0]   pat_len;
    logic                oneline;
    logic [7:0]          stop_byte;
    logic                invert_stop;
    logic [LIMIT_W-1:0]  capture_limit;
  } cfg_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] fold_byte;
    logic       eos;
    logic       sos;
    logic       is_nl;
    logic       is_stop;
    logic       match0;
  } item_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ hdl/hfsc_front.sv @@
// ----------------------------------------------------------------------------
// hfsc_front
// Accepts input items and classifies each byte before it is queued.
// ----------------------------------------------------------------------------
module hfsc_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  input  logic              start_of_stream_i,
  input  hfsc_pkg::cfg_t    cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output hfsc_pkg::item_t   item_o
);

  logic [7:0] fold_b;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign fold_b     = hfsc_pkg::fold_case(data_byte_i);

  always_comb begin
    item_o.data_byte = data_byte_i;
    item_o.fold_byte = fold_b;
    item_o.eos       = end_of_stream_i;
    item_o.sos       = start_of_stream_i;
    item_o.is_nl     = (data_byte_i == hfsc_pkg::NEWLINE);
    // stop test with optional inversion
    item_o.is_stop   = cfg_i.invert_stop ? (data_byte_i != cfg_i.stop_byte)
                                         : (data_byte_i == cfg_i.stop_byte);
    item_o.match0    = (fold_b == hfsc_pkg::fold_case(cfg_i.pat_low[7:0]));
  end

endmodule

@@ hdl/hfsc_queue.sv @@
// ----------------------------------------------------------------------------
// hfsc_queue
// Short flop-based queue between the classifying front and the back end.
// ----------------------------------------------------------------------------
`include "header_field_scan_and_capture_assert.svh"

module hfsc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hfsc_pkg::item_t   item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output hfsc_pkg::item_t   item_o
);

  hfsc_pkg::item_t            mem_q [hfsc_pkg::QDEPTH];
  logic [hfsc_pkg::QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [hfsc_pkg::QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [hfsc_pkg::QAW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (hfsc_pkg::QAW+1)'(hfsc_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `HFSC_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= (hfsc_pkg::QAW+1)'(hfsc_pkg::QDEPTH))
  `HFSC_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop_i, cnt_q != '0)
  `HFSC_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1)

endmodule

@@ hdl/hfsc_back.sv @@
// ----------------------------------------------------------------------------
// hfsc_back
// Runs the pattern search and field capture on queued items.
// ----------------------------------------------------------------------------
`include "header_field_scan_and_capture_assert.svh"

module hfsc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hfsc_pkg::cfg_t                  cfg_i,
  input  logic                            q_valid_i,
  input  hfsc_pkg::item_t                 q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic [1:0]                      status_o,
  output logic [hfsc_pkg::COUNT_W-1:0]    captured_length_o,
  output logic                            last_o
);

  localparam int PatBits = 8 * hfsc_pkg::MAX_PATTERN;

  hfsc_pkg::phase_e                  phase_q, phase_d;
  logic [hfsc_pkg::PLEN_W-1:0]       mp_q, mp_d;
  logic [hfsc_pkg::COUNT_W-1:0]      cnt_q, cnt_d;

  logic                              out_valid_q, out_valid_d;
  logic [7:0]                        out_byte_q;
  hfsc_pkg::status_e                 out_status_q;
  logic [hfsc_pkg::COUNT_W-1:0]      out_len_q;
  logic                              out_last_q;

  logic                              res_valid;
  logic [7:0]                        res_byte;
  hfsc_pkg::status_e                 res_status;
  logic [hfsc_pkg::COUNT_W-1:0]      res_len;
  logic                              res_last;

  logic [PatBits-1:0]                pat_flat;
  logic [7:0]                        pat [hfsc_pkg::MAX_PATTERN];
  logic [hfsc_pkg::PLEN_W-1:0]       len;
  logic [hfsc_pkg::LIMIT_W-1:0]      lim;
  logic                              pat0_nl;
  logic                              not_found;
  hfsc_pkg::item_t                   it;

  assign pat_flat = {cfg_i.pat_high, cfg_i.pat_mid, cfg_i.pat_low};

  for (genvar i = 0; i < hfsc_pkg::MAX_PATTERN; i++) begin : g_pat
    assign pat[i] = pat_flat[i*8 +: 8];
  end

  assign pat0_nl = (pat[0] == hfsc_pkg::NEWLINE);
  assign it      = q_item_i;
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    len = cfg_i.pat_len;
    if (cfg_i.pat_len > hfsc_pkg::PLEN_W'(hfsc_pkg::MAX_PATTERN)) begin
      len = hfsc_pkg::PLEN_W'(hfsc_pkg::MAX_PATTERN);
    end
    lim = cfg_i.capture_limit;
    if (cfg_i.capture_limit == '0) begin
      lim = hfsc_pkg::LIMIT_W'(1);
    end else if (cfg_i.capture_limit > hfsc_pkg::LIMIT_W'(hfsc_pkg::MAX_CAPTURE)) begin
      lim = hfsc_pkg::LIMIT_W'(hfsc_pkg::MAX_CAPTURE);
    end
  end

  // next state and result for the item at the queue head
  always_comb begin
    phase_d    = phase_q;
    mp_d       = mp_q;
    cnt_d      = cnt_q;
    res_valid  = 1'b0;
    res_byte   = '0;
    res_status = hfsc_pkg::ST_BYTE;
    res_len    = '0;
    res_last   = 1'b0;
    not_found  = 1'b0;
    if (q_pop_o) begin
      if (it.sos) begin
        phase_d = hfsc_pkg::PH_SEARCH;
        mp_d    = '0;
        cnt_d   = '0;
        // leading newline in the pattern matches the stream start
        if (len != '0 && pat0_nl) begin
          mp_d = hfsc_pkg::PLEN_W'(1);
          if (len == hfsc_pkg::PLEN_W'(1)) begin
            phase_d = hfsc_pkg::PH_CAPTURE;
          end
        end
      end
      case (phase_d)
        hfsc_pkg::PH_SEARCH: begin
          if (len == '0) begin
            not_found = 1'b1;
          end else begin
            if (mp_d >= len) begin
              mp_d = '0;
            end
            if (it.eos) begin
              not_found = 1'b1;
            end else if (cfg_i.oneline && it.is_nl && (mp_d != '0 || !pat0_nl)) begin
              not_found = 1'b1;
            end else if (mp_d == '0) begin
              if (it.match0) begin
                mp_d = hfsc_pkg::PLEN_W'(1);
              end
            end else if (it.fold_byte ==
                         hfsc_pkg::fold_case(pat[mp_d[hfsc_pkg::PAT_IDX_W-1:0]])) begin
              mp_d = mp_d + 1'b1;
            end else begin
              mp_d = '0;
            end
          end
          if (not_found) begin
            phase_d    = hfsc_pkg::PH_FINISHED;
            res_valid  = 1'b1;
            res_status = hfsc_pkg::ST_NOT_FOUND;
            res_last   = 1'b1;
          end else if (mp_d >= len) begin
            phase_d = hfsc_pkg::PH_CAPTURE;
            cnt_d   = '0;
          end
        end
        hfsc_pkg::PH_CAPTURE: begin
          res_valid = 1'b1;
          res_len   = cnt_d;
          if (it.eos) begin
            phase_d    = hfsc_pkg::PH_FINISHED;
            res_status = hfsc_pkg::ST_ERROR;
            res_last   = 1'b1;
          end else if (it.is_stop) begin
            phase_d    = hfsc_pkg::PH_FINISHED;
            res_status = hfsc_pkg::ST_DONE;
            res_last   = 1'b1;
          end else if ({1'b0, cnt_d} + 1'b1 >= lim) begin
            phase_d    = hfsc_pkg::PH_FINISHED;
            res_status = hfsc_pkg::ST_ERROR;
            res_last   = 1'b1;
          end else begin
            cnt_d    = cnt_d + 1'b1;
            res_len  = cnt_d;
            res_byte = it.data_byte;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hfsc_pkg::PH_IDLE;
      mp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mp_q        <= mp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && res_valid) begin
      out_byte_q   <= res_byte;
      out_status_q <= res_status;
      out_len_q    <= res_len;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign status_o          = out_status_q;
  assign captured_length_o = out_len_q;
  assign last_o            = out_last_q;

  `HFSC_ASSERT_IMP(a_final_is_last, clk_i, rst_ni, out_valid_q && out_status_q != hfsc_pkg::ST_BYTE, out_last_q && out_byte_q == '0)
  `HFSC_ASSERT_IMP(a_byte_counted, clk_i, rst_ni, out_valid_q && out_status_q == hfsc_pkg::ST_BYTE, !out_last_q && out_len_q != '0)
  `HFSC_ASSERT_NEXT(a_byte_keeps_capture, clk_i, rst_ni, q_pop_o && res_valid && res_status == hfsc_pkg::ST_BYTE, phase_q == hfsc_pkg::PH_CAPTURE)

endmodule

@@ hdl/header_field_scan_and_capture.sv @@
// ----------------------------------------------------------------------------
// header_field_scan_and_capture
// Case-folding pattern search over a byte stream, then capture of the field.
// ----------------------------------------------------------------------------
// a result passes through the queue and then the back end's output register
// throughput: one item per cycle unless stalled, set by the back end's match step
// a four-entry queue lets the input side run on while the output is stalled
// reset clears phase, match position, count, queue and output valid at once
// configuration registers return to their reset values; no clearing pass
module header_field_scan_and_capture (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_stream_i,
  input  logic                          start_of_stream_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic [1:0]                    status_o,
  output logic [hfsc_pkg::COUNT_W-1:0]  captured_length_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);

  hfsc_pkg::cfg_t   cfg_q, cfg_d;
  hfsc_pkg::item_t  front_item;
  hfsc_pkg::item_t  head_item;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hfsc_pkg::REG_PAT_LOW:   cfg_d.pat_low       = cfg_data_i;
        hfsc_pkg::REG_PAT_MID:   cfg_d.pat_mid       = cfg_data_i;
        hfsc_pkg::REG_PAT_HIGH:  cfg_d.pat_high      = cfg_data_i;
        hfsc_pkg::REG_PAT_LEN:   cfg_d.pat_len       = cfg_data_i[hfsc_pkg::PLEN_W-1:0];
        hfsc_pkg::REG_ONELINE:   cfg_d.oneline       = cfg_data_i[0];
        hfsc_pkg::REG_STOP_BYTE: cfg_d.stop_byte     = cfg_data_i[7:0];
        hfsc_pkg::REG_INVERT:    cfg_d.invert_stop   = cfg_data_i[0];
        hfsc_pkg::REG_LIMIT:     cfg_d.capture_limit = cfg_data_i[hfsc_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_low       <= '0;
      cfg_q.pat_mid       <= '0;
      cfg_q.pat_high      <= '0;
      cfg_q.pat_len       <= '0;
      cfg_q.oneline       <= 1'b0;
      cfg_q.stop_byte     <= hfsc_pkg::STOP_RESET;
      cfg_q.invert_stop   <= 1'b0;
      cfg_q.capture_limit <= hfsc_pkg::LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hfsc_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .end_of_stream_i   (end_of_stream_i),
    .start_of_stream_i (start_of_stream_i),
    .cfg_i             (cfg_q),
    .q_full_i          (q_full),
    .push_o            (push),
    .item_o            (front_item)
  );

  hfsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  hfsc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid),
    .q_item_i          (head_item),
    .q_pop_o           (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .status_o          (status_o),
    .captured_length_o (captured_length_o),
    .last_o            (last_o)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// header_field_scan_and_capture testbench
// Drives byte streams through the header scanner under random register
// settings, predicts every capture, done, not-found and error item in a
// tracker class and compares each delivered item field by field.
// ----------------------------------------------------------------------------

import hfsc_pkg::*;

typedef struct packed {
  logic [7:0]         out_byte;
  status_e            status;
  logic [COUNT_W-1:0] length;
  logic               last;
} field_result_t;

// running copy of the scanner state plus the queue of items still owed
class field_capture_tracker;
  logic [63:0]        pat_word [3] = '{default: '0};
  logic [PLEN_W-1:0]  pat_len      = '0;
  bit                 oneline      = 1'b0;
  logic [7:0]         stop_byte    = STOP_RESET;
  bit                 invert_stop  = 1'b0;
  logic [LIMIT_W-1:0] limit        = LIMIT_RESET;
  phase_e             phase        = PH_IDLE;
  int unsigned        match_pos    = 0;
  int unsigned        count        = 0;
  field_result_t      owed_q [$];
  int                 errors       = 0;
  int                 active_items = 0;
  int                 sent_items   = 0;
  int                 results      = 0;
  int                 settings     = 0;
  int                 status_seen [4] = '{default: 0};

  function int pending();
    return owed_q.size();
  endfunction

  function logic [7:0] lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  function logic [7:0] pattern_at(input int unsigned i);
    return pat_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function void write_reg(input logic [2:0] idx, input logic [63:0] d);
    case (idx)
      REG_PAT_LOW:   pat_word[0] = d;
      REG_PAT_MID:   pat_word[1] = d;
      REG_PAT_HIGH:  pat_word[2] = d;
      REG_PAT_LEN:   pat_len = d[PLEN_W-1:0];
      REG_ONELINE:   oneline = d[0];
      REG_STOP_BYTE: stop_byte = d[7:0];
      REG_INVERT:    invert_stop = d[0];
      REG_LIMIT:     limit = d[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function void owe(input logic [7:0] b, input status_e st, input int unsigned n,
                    input bit fin);
    field_result_t r;
    r.out_byte = b;
    r.status   = st;
    r.length   = n[COUNT_W-1:0];
    r.last     = fin;
    owed_q.push_back(r);
    if (fin) phase = PH_FINISHED;
  endfunction

  function void scan_byte(input logic [7:0] b, input bit eos, input bit sos);
    int unsigned len;
    int unsigned lim;
    bit          at_stop;
    len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
    lim = (limit == 0) ? 1 : (limit > MAX_CAPTURE) ? MAX_CAPTURE : limit;
    sent_items++;
    if (sos || phase == PH_SEARCH || phase == PH_CAPTURE) active_items++;

    if (sos) begin
      phase     = PH_SEARCH;
      match_pos = 0;
      count     = 0;
      // a leading newline in the pattern stands for the start of the stream
      if (len > 0 && pattern_at(0) == NEWLINE) begin
        match_pos = 1;
        if (len == 1) phase = PH_CAPTURE;
      end
    end

    if (phase == PH_SEARCH) begin
      if (match_pos >= len) match_pos = 0;
      if (len == 0 || eos) begin
        owe('0, ST_NOT_FOUND, 0, 1'b1);
      end else if (oneline && b == NEWLINE &&
                   (match_pos != 0 || pattern_at(0) != NEWLINE)) begin
        owe('0, ST_NOT_FOUND, 0, 1'b1);
      end else begin
        // no backtracking: the failing byte is not tried against byte 0
        if (lower(b) == lower(pattern_at(match_pos))) match_pos++;
        else match_pos = 0;
        if (match_pos >= len) begin
          phase = PH_CAPTURE;
          count = 0;
        end
      end
    end else if (phase == PH_CAPTURE) begin
      at_stop = invert_stop ? (b != stop_byte) : (b == stop_byte);
      if (eos) begin
        owe('0, ST_ERROR, count, 1'b1);
      end else if (at_stop) begin
        owe('0, ST_DONE, count, 1'b1);
      end else if (count + 1 >= lim) begin
        owe('0, ST_ERROR, count, 1'b1);
      end else begin
        count++;
        owe(b, ST_BYTE, count, 1'b0);
      end
    end
  endfunction

  function void compare_output(input logic [7:0] ob, input logic [1:0] st,
                               input logic [COUNT_W-1:0] n, input logic fin);
    field_result_t want;
    if (owed_q.size() == 0) begin
      $error("unexpected item: status %0d byte %0h length %0d", st, ob, n);
      errors++;
      return;
    end
    want = owed_q.pop_front();
    results++;
    status_seen[want.status]++;
    if (ob !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, ob);
      errors++;
    end
    if (st !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, st);
      errors++;
    end
    if (n !== want.length) begin
      $error("captured_length: expected %0d, got %0d", want.length, n);
      errors++;
    end
    if (fin !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, fin);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int RANDOM_ITEMS   = 470;
  localparam int LONG_FIELD     = 1030;
  localparam int CALM_ITEMS     = 150;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i       = '0;
  logic               end_of_stream_i   = 1'b0;
  logic               start_of_stream_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [7:0]         out_byte_o;
  logic [1:0]         status_o;
  logic [COUNT_W-1:0] captured_length_o;
  logic               last_o;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i       = '0;
  logic [63:0]        cfg_data_i        = '0;

  field_capture_tracker tracker;
  cfg_t                 cur_cfg;
  int                   gap_odds    = 0;
  int                   stall_odds  = 0;
  bit                   draining    = 1'b0;
  int                   stall_left  = 0;
  int                   idle_cycles = 0;

  header_field_scan_and_capture DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .end_of_stream_i   (end_of_stream_i),
    .start_of_stream_i (start_of_stream_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .status_o          (status_o),
    .captured_length_o (captured_length_o),
    .last_o            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // output back-pressure in bursts of random length
  always @(negedge clk_i) begin
    if (draining || stall_odds == 0) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(1, stall_odds) == 1) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.compare_output(out_byte_o, status_o, captured_length_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("header_field_scan_and_capture regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] b, input bit eos, input bit sos);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    data_byte_i       <= b;
    end_of_stream_i   <= eos;
    start_of_stream_i <= sos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.scan_byte(b, eos, sos);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, i == 0);
  endtask

  // wait for every owed item, then let any result-less items run through
  task automatic drain();
    in_valid_i <= 1'b0;
    draining = 1'b1;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    draining = 1'b0;
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [63:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.write_reg(idx, d);
    @(negedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    put_reg(REG_PAT_LOW, c.pat_low);
    put_reg(REG_PAT_MID, c.pat_mid);
    put_reg(REG_PAT_HIGH, c.pat_high);
    put_reg(REG_PAT_LEN, 64'(c.pat_len));
    put_reg(REG_ONELINE, 64'(c.oneline));
    put_reg(REG_STOP_BYTE, 64'(c.stop_byte));
    put_reg(REG_INVERT, 64'(c.invert_stop));
    put_reg(REG_LIMIT, 64'(c.capture_limit));
    cfg_valid_i <= 1'b0;
    tracker.settings++;
  endtask

  function automatic logic [191:0] pattern_words(input string s);
    logic [191:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < MAX_PATTERN; i++) w[i * 8 +: 8] = s[i];
    return w;
  endfunction

  function automatic logic [7:0] letter();
    logic [7:0] b;
    b = 8'h61 + 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? b ^ 8'h20 : b;
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] b);
    if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
        $urandom_range(0, 1)) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  function automatic cfg_t random_config();
    cfg_t         c;
    logic [191:0] w;
    int           len;
    int           r;
    w   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r   = $urandom_range(0, 19);
    len = (r == 0) ? 0 :
          (r == 1) ? $urandom_range(25, 31) :
          (r < 5)  ? $urandom_range(9, 24) : $urandom_range(1, 8);
    for (int i = 0; i < len && i < MAX_PATTERN; i++) begin
      if ($urandom_range(0, 3) != 0) w[i * 8 +: 8] = letter();
    end
    if ($urandom_range(0, 3) == 0) w[7:0] = NEWLINE;
    c.pat_len       = PLEN_W'(len);
    c.oneline       = 1'($urandom_range(0, 1));
    c.stop_byte     = $urandom_range(0, 2) == 0 ? STOP_RESET : 8'($urandom_range(0, 255));
    c.invert_stop   = $urandom_range(0, 3) == 0;
    r = $urandom_range(0, 9);
    c.capture_limit = (r == 0) ? LIMIT_W'(0) :
                      (r == 1) ? LIMIT_W'(1) :
                      (r == 2) ? LIMIT_W'(MAX_CAPTURE) :
                      (r == 3) ? LIMIT_W'($urandom_range(MAX_CAPTURE + 1, 2047)) :
                                 LIMIT_W'($urandom_range(2, 40));
    if ($urandom_range(0, 9) == 0) begin
      w             = pattern_words("\nMessage-Id: <");
      c.pat_len     = PLEN_W'(14);
      c.stop_byte   = STOP_RESET;
      c.invert_stop = 1'b0;
    end
    {c.pat_high, c.pat_mid, c.pat_low} = w;
    return c;
  endfunction

  // one message: mostly noise, the pattern and a field, sometimes broken off
  task automatic send_message(input int long_field);
    logic [7:0]   seq [$];
    logic [191:0] pw;
    int           len;
    int           lim;
    int           kind;
    int           flen;
    int           cut;
    int           first;
    int           ending;
    bit           tail_eos;
    bit           sos_eos;
    pw       = {cur_cfg.pat_high, cur_cfg.pat_mid, cur_cfg.pat_low};
    len      = (cur_cfg.pat_len > MAX_PATTERN) ? MAX_PATTERN : cur_cfg.pat_len;
    lim      = (cur_cfg.capture_limit == 0) ? 1 :
               (cur_cfg.capture_limit > MAX_CAPTURE) ? MAX_CAPTURE : cur_cfg.capture_limit;
    kind     = (long_field > 0) ? 0 : $urandom_range(0, 9);
    tail_eos = 1'b0;
    sos_eos  = 1'b0;

    repeat ($urandom_range(0, 4)) begin
      seq.push_back($urandom_range(0, 2) == 0 ? byte_other_than(NEWLINE) : letter());
    end

    if (kind <= 6) begin
      first = (seq.size() == 0 && len > 0 && pw[7:0] == NEWLINE &&
               $urandom_range(0, 3) != 0) ? 1 : 0;
      for (int i = first; i < len; i++) seq.push_back(mix_case(pw[i * 8 +: 8]));
      if (long_field > 0) flen = long_field;
      else if (lim <= 64 && $urandom_range(0, 3) == 0)
        flen = $urandom_range(lim > 2 ? lim - 2 : 0, lim + 1);
      else flen = $urandom_range(0, 8);
      repeat (flen) begin
        seq.push_back(cur_cfg.invert_stop ? cur_cfg.stop_byte
                                          : byte_other_than(cur_cfg.stop_byte));
      end
      ending = (long_field > 0) ? 9 : $urandom_range(0, 9);
      if (ending == 0) begin
        tail_eos = 1'b1;
      end else if (ending >= 2) begin
        seq.push_back(cur_cfg.invert_stop ? byte_other_than(cur_cfg.stop_byte)
                                          : cur_cfg.stop_byte);
        if ($urandom_range(0, 3) == 0) seq.push_back(8'($urandom_range(0, 255)));
      end
    end else if (kind <= 8) begin
      // pattern cut short, then end of stream, a newline, a stray byte or nothing
      cut = (len > 0) ? $urandom_range(0, len - 1) : 0;
      for (int i = 0; i < cut; i++) seq.push_back(mix_case(pw[i * 8 +: 8]));
      ending = $urandom_range(0, 3);
      if (ending == 0) tail_eos = 1'b1;
      else if (ending == 1) seq.push_back(NEWLINE);
      else if (ending == 2) seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 12)) seq.push_back(8'($urandom_range(0, 255)));
      sos_eos  = $urandom_range(0, 3) == 0;
      tail_eos = $urandom_range(0, 1);
    end

    if (seq.size() == 0) seq.push_back(8'($urandom_range(0, 255)));
    foreach (seq[i]) send_item(seq[i], sos_eos && i == 0, i == 0);
    if (tail_eos) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  initial begin
    int base;
    int phase_no;
    int remaining;
    int r;
    tracker = new;
    cur_cfg = '{pat_low: '0, pat_mid: '0, pat_high: '0, pat_len: '0, oneline: 1'b0,
                stop_byte: STOP_RESET, invert_stop: 1'b0, capture_limit: LIMIT_RESET};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty pattern after reset: start item is not found, the rest ignored
    send_item("A", 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);

    // lone newline pattern captures from the start item; zero limit acts as one
    drain();
    {cur_cfg.pat_high, cur_cfg.pat_mid, cur_cfg.pat_low} = pattern_words("\n");
    cur_cfg.pat_len       = PLEN_W'(1);
    cur_cfg.capture_limit = '0;
    apply_config(cur_cfg);
    send_item(8'hFF, 1'b0, 1'b1);

    // oversized limit, inverted stop on a zero stop byte
    drain();
    cur_cfg.capture_limit = '1;
    cur_cfg.invert_stop   = 1'b1;
    cur_cfg.stop_byte     = 8'h00;
    apply_config(cur_cfg);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);

    // folded match, no re-examination after a mismatch, limit overflow
    drain();
    {cur_cfg.pat_high, cur_cfg.pat_mid, cur_cfg.pat_low} = pattern_words("aB");
    cur_cfg.pat_len       = PLEN_W'(2);
    cur_cfg.oneline       = 1'b1;
    cur_cfg.stop_byte     = STOP_RESET;
    cur_cfg.invert_stop   = 1'b0;
    cur_cfg.capture_limit = LIMIT_W'(3);
    apply_config(cur_cfg);
    send_text("AAbabxyz");
    send_text("a\n");
    send_text("\n");
    send_text("q");
    send_item(8'h00, 1'b1, 1'b0);
    send_text("ab>");

    // pattern shortened mid-search, then end of stream while capturing
    send_text("a");
    drain();
    cur_cfg.pat_len = PLEN_W'(1);
    apply_config(cur_cfg);
    send_item("a", 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);

    base     = tracker.sent_items;
    phase_no = 0;
    remaining = RANDOM_ITEMS + LONG_FIELD;
    while (remaining > 0) begin
      drain();
      cur_cfg = random_config();
      if (phase_no == 1) begin
        // one field long enough to run into the full capture limit
        {cur_cfg.pat_high, cur_cfg.pat_mid, cur_cfg.pat_low} = pattern_words("Subject: ");
        cur_cfg.pat_len       = PLEN_W'(9);
        cur_cfg.oneline       = 1'b0;
        cur_cfg.invert_stop   = 1'b0;
        cur_cfg.capture_limit = '1;
      end
      apply_config(cur_cfg);
      if (remaining < CALM_ITEMS) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        r          = $urandom_range(0, 3);
        gap_odds   = (r == 0) ? 0 : $urandom_range(2, 8);
        r          = $urandom_range(0, 3);
        stall_odds = (r == 0) ? 0 : $urandom_range(2, 8);
      end
      if (phase_no == 1) begin
        send_message(LONG_FIELD);
      end else begin
        repeat ($urandom_range(4, 10)) begin
          send_message(0);
          if ($urandom_range(0, 15) == 0) drain();
        end
      end
      phase_no++;
      remaining = RANDOM_ITEMS + LONG_FIELD - (tracker.sent_items - base);
    end

    drain();
    if (tracker.pending() != 0) begin
      $error("%0d expected items never arrived", tracker.pending());
      tracker.errors++;
    end
    $display("covered %0d sent items, %0d of them scanned, %0d results, %0d register settings",
             tracker.sent_items, tracker.active_items, tracker.results, tracker.settings);
    $display("results: %0d bytes, %0d done, %0d not found, %0d missing stop or overflow",
             tracker.status_seen[ST_BYTE], tracker.status_seen[ST_DONE],
             tracker.status_seen[ST_NOT_FOUND], tracker.status_seen[ST_ERROR]);
    if (tracker.errors == 0) begin
      $display("header_field_scan_and_capture regression: pass");
    end else begin
      $display("header_field_scan_and_capture regression: fail");
    end
    $finish;
  end
endmodule
